// ===== design/stt_pkg.sv =====
// ----------------------------------------------------------------------------
// stt_pkg: shared types and constants of the source text tokenizer
// Byte classes, token codes, scanner modes and the keyword tables.
// ----------------------------------------------------------------------------
package stt_pkg;

  // Default depth of the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;
  // Result queue depth inside the back part (takes up to two results per cycle)
  localparam int unsigned OUT_DEPTH   = 4;

  // Character codes
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_LBRC  = 8'h7B;
  localparam logic [7:0] CH_RBRC  = 8'h7D;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_SEMI  = 8'h3B;

  // Token codes
  typedef enum logic [3:0] {
    TK_EOF     = 4'd0,
    TK_LPAREN  = 4'd1,
    TK_RPAREN  = 4'd2,
    TK_LBRACE  = 4'd3,
    TK_RBRACE  = 4'd4,
    TK_COMMA   = 4'd5,
    TK_SEMI    = 4'd6,
    TK_STRING  = 4'd7,
    TK_INT     = 4'd8,
    TK_IDENT   = 4'd9,
    TK_FUNC    = 4'd10,
    TK_RETURN  = 4'd11,
    TK_SHH     = 4'd12,
    TK_BOOL    = 4'd13,
    TK_INVALID = 4'd14,
    TK_UNTERM  = 4'd15
  } tok_e;

  // Result item kinds
  localparam logic KIND_VALUE = 1'b0;
  localparam logic KIND_TOKEN = 1'b1;

  // Request types
  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_END  = 1'b1;

  // Scanner modes
  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_SLASH   = 3'd1,
    MODE_COMMENT = 3'd2,
    MODE_IDENT   = 3'd3,
    MODE_NUMBER  = 3'd4,
    MODE_STRING  = 3'd5
  } mode_e;

  // Keyword tables: func, return, shh, true, false
  localparam int unsigned KW_COUNT = 5;
  localparam logic [KW_COUNT-1:0] KW_ALL = '1;
  localparam logic [2:0] KW_LEN [KW_COUNT] = '{3'd4, 3'd6, 3'd3, 3'd4, 3'd5};
  localparam tok_e KW_KIND [KW_COUNT] = '{TK_FUNC, TK_RETURN, TK_SHH, TK_BOOL, TK_BOOL};
  localparam logic [7:0] KW_TEXT [KW_COUNT][8] = '{
    '{8'h66, 8'h75, 8'h6E, 8'h63, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h72, 8'h65, 8'h74, 8'h75, 8'h72, 8'h6E, 8'h00, 8'h00},
    '{8'h73, 8'h68, 8'h68, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h74, 8'h72, 8'h75, 8'h65, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h66, 8'h61, 8'h6C, 8'h73, 8'h65, 8'h00, 8'h00, 8'h00}
  };

  // Classified input item
  typedef struct packed {
    logic       is_end;
    logic [7:0] ch;
    logic       sp;
    logic       dig;
    logic       alp;
    logic       und;
    logic       slash;
    logic       quote;
    logic       lf;
    tok_e       sym;   // TK_EOF when the byte is no symbol
  } cls_t;

  // One result item
  typedef struct packed {
    logic       item_kind;
    logic [7:0] value_byte;
    tok_e       token_kind;
    logic       last;
  } res_t;

endpackage

// ===== design/source_text_tokenizer.sv =====
// ----------------------------------------------------------------------------
// source_text_tokenizer: streaming lexical analyser
// Turns source bytes into token value bytes and token-complete results.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata                               | tuser     | tlast
//  s_axis   | in  | [7:0] char_code                     | req_type  | -
//  m_axis   | out | [7:0] value_byte, [11:8] token_kind | item_kind | last
//
// One item per cycle sustained; inputs pass the item queue, then the result queue.
// The output drains one result per cycle, so a run of items that each yield
// two results (a token ended by the next byte, or the end marker) holds the
// scanner back; an isolated one is absorbed by the result queue.
// Reset clears both queues and returns the scanner to between tokens.
// Either side may stall: the item queue lets input run ahead of the scanner.
// ----------------------------------------------------------------------------
module source_text_tokenizer #(
  parameter int unsigned QueueDepth = stt_pkg::QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
  input  logic        s_axis_tuser,   // req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] value_byte, [11:8] token_kind
  output logic        m_axis_tuser,   // item_kind
  output logic        m_axis_tlast    // last
);

  logic          push, q_full, q_valid, pop;
  stt_pkg::cls_t cls_in, cls_head;
  stt_pkg::res_t res;

  // Classifier
  stt_front u_front (
    .in_valid_i (s_axis_tvalid),
    .in_type_i  (s_axis_tuser),
    .in_char_i  (s_axis_tdata),
    .q_full_i   (q_full),
    .in_ready_o (s_axis_tready),
    .push_o     (push),
    .cls_o      (cls_in)
  );

  // Item queue
  stt_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (cls_in),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .rdata_o (cls_head)
  );

  // Scanner
  stt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (q_valid),
    .cls_i       (cls_head),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_res_o   (res)
  );

  assign m_axis_tdata = {4'h0, res.token_kind, res.value_byte};
  assign m_axis_tuser = res.item_kind;
  assign m_axis_tlast = res.last;

endmodule

// ===== design/stt_front.sv =====
// ----------------------------------------------------------------------------
// stt_front: input classifier
// Accepts source items and tags each byte with its character class.
// ----------------------------------------------------------------------------
module stt_front (
  input  logic          in_valid_i,
  input  logic          in_type_i,
  input  logic [7:0]    in_char_i,
  input  logic          q_full_i,
  output logic          in_ready_o,
  output logic          push_o,
  output stt_pkg::cls_t cls_o
);

  // Handshake towards the queue
  assign in_ready_o = ~q_full_i;
  assign push_o     = in_valid_i & ~q_full_i;

  // Character classes
  always_comb begin
    cls_o        = '0;
    cls_o.is_end = (in_type_i == stt_pkg::REQ_END);
    cls_o.ch     = in_char_i;
    cls_o.sp     = (in_char_i == stt_pkg::CH_SPACE) ||
                   (in_char_i inside {[stt_pkg::CH_TAB:stt_pkg::CH_CR]});
    cls_o.dig    = in_char_i inside {[8'h30:8'h39]};
    cls_o.alp    = (in_char_i inside {[8'h61:8'h7A]}) || (in_char_i inside {[8'h41:8'h5A]});
    cls_o.und    = (in_char_i == stt_pkg::CH_UNDER);
    cls_o.slash  = (in_char_i == stt_pkg::CH_SLASH);
    cls_o.quote  = (in_char_i == stt_pkg::CH_QUOTE);
    cls_o.lf     = (in_char_i == stt_pkg::CH_LF);
    case (in_char_i)
      stt_pkg::CH_LPAR:  cls_o.sym = stt_pkg::TK_LPAREN;
      stt_pkg::CH_RPAR:  cls_o.sym = stt_pkg::TK_RPAREN;
      stt_pkg::CH_LBRC:  cls_o.sym = stt_pkg::TK_LBRACE;
      stt_pkg::CH_RBRC:  cls_o.sym = stt_pkg::TK_RBRACE;
      stt_pkg::CH_COMMA: cls_o.sym = stt_pkg::TK_COMMA;
      stt_pkg::CH_SEMI:  cls_o.sym = stt_pkg::TK_SEMI;
      default:           cls_o.sym = stt_pkg::TK_EOF;
    endcase
  end

endmodule

// ===== design/stt_fifo.sv =====
// ----------------------------------------------------------------------------
// stt_fifo: classified item queue
// Small register queue between the classifier and the scanner.
// ----------------------------------------------------------------------------
module stt_fifo #(
  parameter int unsigned Depth = stt_pkg::QUEUE_DEPTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  stt_pkg::cls_t wdata_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output stt_pkg::cls_t rdata_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  stt_pkg::cls_t   mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntFull);
  assign valid_o = (cnt_q != '0);
  assign rdata_o = mem_q[rd_q];

  // Pointer and fill count
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PtrLast) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == PtrLast) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

endmodule

// ===== design/stt_back.sv =====
// ----------------------------------------------------------------------------
// stt_back: token scanner
// Runs the scan state machine on classified items and queues up to two
// results per item for the output channel.
// ----------------------------------------------------------------------------
module stt_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  stt_pkg::cls_t cls_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output stt_pkg::res_t out_res_o
);

  localparam int unsigned PtrW = $clog2(stt_pkg::OUT_DEPTH);
  localparam int unsigned CntW = $clog2(stt_pkg::OUT_DEPTH + 1);
  localparam logic [CntW-1:0] CntRoom = CntW'(stt_pkg::OUT_DEPTH - 2);

  stt_pkg::mode_e                 mode_q, mode_d;
  logic [stt_pkg::KW_COUNT-1:0]   kw_q, kw_d;
  logic [2:0]                     pos_q, pos_d;

  logic          r0_v, r1_v;
  stt_pkg::res_t r0, r1;
  logic          ident_cont;

  stt_pkg::res_t   oq_q [stt_pkg::OUT_DEPTH];
  logic [PtrW-1:0] owr_q, ord_q;
  logic [CntW-1:0] ocnt_q, ocnt_d;
  logic            out_fire;

  // Narrowing keyword flags by one identifier byte
  function automatic logic [stt_pkg::KW_COUNT-1:0] kw_take(
    input logic [stt_pkg::KW_COUNT-1:0] kw,
    input logic [2:0]                   pos,
    input logic [7:0]                   c
  );
    logic [stt_pkg::KW_COUNT-1:0] r;
    r = kw;
    for (int k = 0; k < stt_pkg::KW_COUNT; k++) begin
      if (!((pos < stt_pkg::KW_LEN[k]) && (stt_pkg::KW_TEXT[k][pos] == c))) begin
        r[k] = 1'b0;
      end
    end
    return r;
  endfunction

  // Kind of a finished identifier, first matching keyword wins
  function automatic stt_pkg::tok_e ident_kind(
    input logic [stt_pkg::KW_COUNT-1:0] kw,
    input logic [2:0]                   pos
  );
    stt_pkg::tok_e r;
    r = stt_pkg::TK_IDENT;
    for (int k = stt_pkg::KW_COUNT - 1; k >= 0; k--) begin
      if (kw[k] && (pos == stt_pkg::KW_LEN[k])) begin
        r = stt_pkg::KW_KIND[k];
      end
    end
    return r;
  endfunction

  function automatic stt_pkg::res_t mk_tok(
    input logic [7:0]    vb,
    input stt_pkg::tok_e tk,
    input logic          last
  );
    stt_pkg::res_t r;
    r.item_kind  = stt_pkg::KIND_TOKEN;
    r.value_byte = vb;
    r.token_kind = tk;
    r.last       = last;
    return r;
  endfunction

  function automatic stt_pkg::res_t mk_val(input logic [7:0] vb);
    stt_pkg::res_t r;
    r.item_kind  = stt_pkg::KIND_VALUE;
    r.value_byte = vb;
    r.token_kind = stt_pkg::TK_EOF;
    r.last       = 1'b0;
    return r;
  endfunction

  // Result of a byte met between tokens; valid flag in the top bit
  function automatic logic [$bits(stt_pkg::res_t):0] idle_res(input stt_pkg::cls_t c);
    logic [$bits(stt_pkg::res_t):0] r;
    if (c.sym != stt_pkg::TK_EOF) begin
      r = {1'b1, mk_tok(8'h00, c.sym, 1'b0)};
    end else if (c.quote || c.slash || c.sp) begin
      r = '0;
    end else if (c.dig || c.alp) begin
      r = {1'b1, mk_val(c.ch)};
    end else begin
      r = {1'b1, mk_tok(c.ch, stt_pkg::TK_INVALID, 1'b0)};
    end
    return r;
  endfunction

  // Mode that a byte met between tokens opens
  function automatic stt_pkg::mode_e idle_mode(input stt_pkg::cls_t c);
    stt_pkg::mode_e m;
    if (c.quote) begin
      m = stt_pkg::MODE_STRING;
    end else if (c.slash) begin
      m = stt_pkg::MODE_SLASH;
    end else if (c.dig) begin
      m = stt_pkg::MODE_NUMBER;
    end else if (c.alp) begin
      m = stt_pkg::MODE_IDENT;
    end else begin
      m = stt_pkg::MODE_IDLE;
    end
    return m;
  endfunction

  assign ident_cont = cls_i.alp || cls_i.dig || cls_i.und;

  // Take an item only when the result queue has room for two
  assign pop_o = valid_i && (ocnt_q <= CntRoom);

  // Next state
  always_comb begin
    mode_d = mode_q;
    kw_d   = kw_q;
    pos_d  = pos_q;
    if (pop_o) begin
      if (cls_i.is_end) begin
        mode_d = stt_pkg::MODE_IDLE;
        kw_d   = stt_pkg::KW_ALL;
        pos_d  = '0;
      end else begin
        case (mode_q)
          stt_pkg::MODE_COMMENT: begin
            if (cls_i.lf) begin
              mode_d = stt_pkg::MODE_IDLE;
            end
          end
          stt_pkg::MODE_STRING: begin
            if (cls_i.quote) begin
              mode_d = stt_pkg::MODE_IDLE;
            end
          end
          stt_pkg::MODE_IDENT: begin
            if (ident_cont) begin
              kw_d  = kw_take(kw_q, pos_q, cls_i.ch);
              pos_d = (pos_q == 3'd7) ? pos_q : pos_q + 3'd1;
            end
          end
          stt_pkg::MODE_NUMBER: begin
            if (cls_i.dig) begin
              mode_d = stt_pkg::MODE_NUMBER;
            end
          end
          default: begin
          end
        endcase
        // Byte handled as between tokens: fresh identifier flags
        if ((mode_q == stt_pkg::MODE_IDLE) ||
            ((mode_q == stt_pkg::MODE_SLASH) && !cls_i.slash) ||
            ((mode_q == stt_pkg::MODE_IDENT) && !ident_cont) ||
            ((mode_q == stt_pkg::MODE_NUMBER) && !cls_i.dig)) begin
          mode_d = idle_mode(cls_i);
          kw_d   = cls_i.alp ? kw_take(stt_pkg::KW_ALL, 3'd0, cls_i.ch) : stt_pkg::KW_ALL;
          pos_d  = cls_i.alp ? 3'd1 : 3'd0;
        end else if ((mode_q == stt_pkg::MODE_SLASH) && cls_i.slash) begin
          mode_d = stt_pkg::MODE_COMMENT;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= stt_pkg::MODE_IDLE;
      kw_q   <= stt_pkg::KW_ALL;
      pos_q  <= '0;
    end else begin
      mode_q <= mode_d;
      kw_q   <= kw_d;
      pos_q  <= pos_d;
    end
  end

  // Results of the current item
  always_comb begin
    r0_v = 1'b0;
    r1_v = 1'b0;
    r0   = mk_val(8'h00);
    r1   = mk_val(8'h00);
    if (cls_i.is_end) begin
      r0_v = 1'b1;
      r1_v = 1'b1;
      r1   = mk_tok(8'h00, stt_pkg::TK_EOF, 1'b1);
      case (mode_q)
        stt_pkg::MODE_SLASH:  r0 = mk_tok(stt_pkg::CH_SLASH, stt_pkg::TK_INVALID, 1'b0);
        stt_pkg::MODE_IDENT:  r0 = mk_tok(8'h00, ident_kind(kw_q, pos_q), 1'b0);
        stt_pkg::MODE_NUMBER: r0 = mk_tok(8'h00, stt_pkg::TK_INT, 1'b0);
        stt_pkg::MODE_STRING: begin
          r0   = mk_tok(8'h00, stt_pkg::TK_UNTERM, 1'b1);
          r1_v = 1'b0;
        end
        default: begin
          r0   = mk_tok(8'h00, stt_pkg::TK_EOF, 1'b1);
          r1_v = 1'b0;
        end
      endcase
    end else begin
      case (mode_q)
        stt_pkg::MODE_SLASH: begin
          if (!cls_i.slash) begin
            r0_v       = 1'b1;
            r0         = mk_tok(stt_pkg::CH_SLASH, stt_pkg::TK_INVALID, 1'b0);
            {r1_v, r1} = idle_res(cls_i);
          end
        end
        stt_pkg::MODE_COMMENT: begin
        end
        stt_pkg::MODE_IDENT: begin
          r0_v = 1'b1;
          if (ident_cont) begin
            r0 = mk_val(cls_i.ch);
          end else begin
            r0         = mk_tok(8'h00, ident_kind(kw_q, pos_q), 1'b0);
            {r1_v, r1} = idle_res(cls_i);
          end
        end
        stt_pkg::MODE_NUMBER: begin
          r0_v = 1'b1;
          if (cls_i.dig) begin
            r0 = mk_val(cls_i.ch);
          end else begin
            r0         = mk_tok(8'h00, stt_pkg::TK_INT, 1'b0);
            {r1_v, r1} = idle_res(cls_i);
          end
        end
        stt_pkg::MODE_STRING: begin
          r0_v = 1'b1;
          r0   = cls_i.quote ? mk_tok(8'h00, stt_pkg::TK_STRING, 1'b0) : mk_val(cls_i.ch);
        end
        default: begin
          {r0_v, r0} = idle_res(cls_i);
        end
      endcase
    end
  end

  // Result queue: up to two writes and one read per cycle
  assign out_valid_o = (ocnt_q != '0);
  assign out_res_o   = oq_q[ord_q];
  assign out_fire    = out_valid_o && out_ready_i;

  always_comb begin
    ocnt_d = ocnt_q;
    if (pop_o) begin
      ocnt_d = ocnt_d + CntW'(r0_v) + CntW'(r1_v);
    end
    if (out_fire) begin
      ocnt_d = ocnt_d - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owr_q  <= '0;
      ord_q  <= '0;
      ocnt_q <= '0;
    end else begin
      ocnt_q <= ocnt_d;
      if (out_fire) begin
        ord_q <= ord_q + 1'b1;
      end
      if (pop_o) begin
        owr_q <= owr_q + PtrW'(r0_v) + PtrW'(r1_v);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && r0_v) begin
      oq_q[owr_q] <= r0;
    end
    if (pop_o && r1_v) begin
      oq_q[owr_q + 1'b1] <= r1;
    end
  end

endmodule
